// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in any cycle where the antecedent holds.
`define SAC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition must never hold.
`define SAC_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== design/sac_pkg.sv =====
// ---------------------------------------------------------------------------
// Swept box collision package
// Normal codes and pipeline latency helpers shared by the collision core.
// ---------------------------------------------------------------------------
package sac_pkg;

    // Face normal codes, two bits signed.
    localparam logic signed [1:0] NORM_ZERO = 2'sb00;
    localparam logic signed [1:0] NORM_POS  = 2'sb01;
    localparam logic signed [1:0] NORM_NEG  = 2'sb11;

    // Cycles from divider input to registered divider result.
    function automatic int div_latency(input int frac_bits);
        return frac_bits + 4;
    endfunction

    // Side information that travels alongside the four divisions.
    typedef struct packed {
        logic xinv_neg;
        logic yinv_neg;
        logic vx_zero;
        logic vy_zero;
    } side_t;

endpackage

// ===== design/sac_div.sv =====
// ---------------------------------------------------------------------------
// Pipelined saturating divider
// Computes sign * min(floor(gap * 2^F / den), 4 * 2^F), one quotient bit
// per pipeline stage.
// ---------------------------------------------------------------------------
module sac_div #(
    parameter int COORD_BITS     = 16,
    parameter int TIME_FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic [COORD_BITS:0]           gap_mag,
    input  logic [COORD_BITS-1:0]         den,
    input  logic                          neg,
    output logic signed [TIME_FRAC_BITS+3:0] quot
);
    import sac_pkg::*;

    localparam int K  = TIME_FRAC_BITS + 2;
    localparam int RW = COORD_BITS + 2;
    localparam int TW = TIME_FRAC_BITS + 4;
    localparam logic [TW-1:0] T_SAT = TW'(4) << TIME_FRAC_BITS;

    logic [RW-1:0]         r_reg   [0:K];
    logic [COORD_BITS-1:0] d_reg   [0:K];
    logic [K-1:0]          q_reg   [0:K];
    logic                  sat_reg [0:K];
    logic                  neg_reg [0:K];
    logic [TW-1:0]         mag;
    logic [TW-1:0]         quot_next;
    logic [TW-1:0]         quot_reg;

    // The quotient is at least four exactly when the gap is at least 4*den.
    always_ff @(posedge clk)
    begin
        r_reg[0]   <= {1'b0, gap_mag};
        d_reg[0]   <= den;
        q_reg[0]   <= '0;
        sat_reg[0] <= ({1'b0, gap_mag} >= {den, 2'b00});
        neg_reg[0] <= neg;
    end

    for (genvar k = 0; k < K; k++) begin : g_step
        logic [RW-1:0] rc;
        logic [RW-1:0] dd;
        logic          take;

        always_comb
        begin
            rc   = (k < 2) ? r_reg[k] : {r_reg[k][RW-2:0], 1'b0};
            dd   = (k == 0) ? {1'b0, d_reg[k], 1'b0} : {2'b00, d_reg[k]};
            take = (rc >= dd);
        end

        always_ff @(posedge clk)
        begin
            r_reg[k+1]   <= take ? (rc - dd) : rc;
            d_reg[k+1]   <= d_reg[k];
            q_reg[k+1]   <= {q_reg[k][K-2:0], take};
            sat_reg[k+1] <= sat_reg[k];
            neg_reg[k+1] <= neg_reg[k];
        end
    end

    always_comb
    begin
        mag       = sat_reg[K] ? T_SAT : {2'b00, q_reg[K]};
        quot_next = neg_reg[K] ? (TW'(0) - mag) : mag;
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
    end

    assign quot = signed'(quot_reg);

endmodule

// ===== design/swept_aabb_collision_core.sv =====
// ---------------------------------------------------------------------------
// Swept axis-aligned box collision core
// Sweeps a moving box against a static box and reports hit, entry time and
// the normal of the struck face.
// ---------------------------------------------------------------------------
// The core takes one box pair in every clock cycle: busy is held low, so a
// transfer happens at each edge where start is high. Each pair gives exactly
// one result, shown for one cycle with done high, after it has passed the
// input and gap registers, the four restoring dividers, the axis time register
// and the output register. The dividers resolve one quotient bit per stage
// over TIME_FRAC_BITS + 2 stages. The receiver cannot stall the core; results
// must be taken as they appear. Entry time is in Q1.TIME_FRAC_BITS and reads
// as 1.0 with a zero normal on a miss.
module swept_aabb_collision_core #(
    parameter int COORD_BITS     = 16,
    parameter int TIME_FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_BITS-1:0]  mover_x,
    input  logic signed [COORD_BITS-1:0]  mover_y,
    input  logic [COORD_BITS-2:0]         mover_width,
    input  logic [COORD_BITS-2:0]         mover_height,
    input  logic signed [COORD_BITS-1:0]  mover_vx,
    input  logic signed [COORD_BITS-1:0]  mover_vy,
    input  logic signed [COORD_BITS-1:0]  target_x,
    input  logic signed [COORD_BITS-1:0]  target_y,
    input  logic [COORD_BITS-2:0]         target_width,
    input  logic [COORD_BITS-2:0]         target_height,
    output logic                          done,
    output logic                          hit,
    output logic [TIME_FRAC_BITS:0]       entry_time,
    output logic signed [1:0]             normal_x,
    output logic signed [1:0]             normal_y
);
    import sac_pkg::*;

    `include "assert_macros.svh"

    localparam int C        = COORD_BITS;
    localparam int GW       = COORD_BITS + 2;
    localparam int TW       = TIME_FRAC_BITS + 4;
    localparam int DIV_LAT  = div_latency(TIME_FRAC_BITS);
    localparam int PIPE_LAT = DIV_LAT + 4;
    localparam logic signed [TW-1:0] T_ONE = TW'(1) << TIME_FRAC_BITS;
    localparam logic signed [TW-1:0] T_SAT = TW'(4) << TIME_FRAC_BITS;

    // Stage 0: captured inputs.
    logic                 s0_valid_reg;
    logic signed [C-1:0]  s0_x1_reg, s0_y1_reg, s0_vx_reg, s0_vy_reg;
    logic signed [C-1:0]  s0_x2_reg, s0_y2_reg;
    logic [C-2:0]         s0_w1_reg, s0_h1_reg, s0_w2_reg, s0_h2_reg;

    // Stage 1: gaps as magnitudes and signs, ready for division.
    logic                 s1_valid_reg;
    logic [C:0]           s1_xen_mag_reg, s1_xex_mag_reg;
    logic [C:0]           s1_yen_mag_reg, s1_yex_mag_reg;
    logic                 s1_xen_neg_reg, s1_xex_neg_reg;
    logic                 s1_yen_neg_reg, s1_yex_neg_reg;
    logic [C-1:0]         s1_vx_mag_reg, s1_vy_mag_reg;
    side_t                s1_side_reg;

    // Stage 1 combinational values.
    logic signed [GW-1:0] x_near, x_far, y_near, y_far;
    logic signed [GW-1:0] xen_gap, xex_gap, yen_gap, yex_gap;
    logic signed [GW-1:0] vx_ext, vy_ext;
    logic                 vx_neg, vy_neg;
    logic signed [GW-1:0] xen_abs, xex_abs, yen_abs, yex_abs, vx_abs, vy_abs;
    side_t                s1_side_next;

    // Divider results and the delayed side information.
    logic signed [TW-1:0] xen_q, xex_q, yen_q, yex_q;
    logic                 dv_valid_reg [0:DIV_LAT-1];
    side_t                dv_side_reg  [0:DIV_LAT-1];

    // Stage m1: axis times with the zero velocity override.
    logic                 m1_valid_reg;
    logic signed [TW-1:0] m1_xen_reg, m1_xex_reg, m1_yen_reg, m1_yex_reg;
    logic                 m1_xinv_neg_reg, m1_yinv_neg_reg;

    // Stage m2: decision.
    logic signed [TW-1:0] t_in, t_out;
    logic                 miss;
    logic                 x_face;
    logic                 hit_next;
    logic [TIME_FRAC_BITS:0] entry_time_next;
    logic signed [1:0]    normal_x_next, normal_y_next;
    logic                 done_reg, hit_reg;
    logic [TIME_FRAC_BITS:0] entry_time_reg;
    logic signed [1:0]    normal_x_reg, normal_y_reg;

    // Every stage moves on every cycle, so a pair is always taken.
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_x1_reg <= mover_x;
        s0_y1_reg <= mover_y;
        s0_w1_reg <= mover_width;
        s0_h1_reg <= mover_height;
        s0_vx_reg <= mover_vx;
        s0_vy_reg <= mover_vy;
        s0_x2_reg <= target_x;
        s0_y2_reg <= target_y;
        s0_w2_reg <= target_width;
        s0_h2_reg <= target_height;
    end

    // The near gap is the one in the direction of travel; for a still or
    // backward axis the two gaps swap roles.
    always_comb
    begin
        x_near = GW'(s0_x2_reg) - (GW'(s0_x1_reg) + signed'({3'b000, s0_w1_reg}));
        x_far  = (GW'(s0_x2_reg) + signed'({3'b000, s0_w2_reg})) - GW'(s0_x1_reg);
        y_near = GW'(s0_y2_reg) - (GW'(s0_y1_reg) + signed'({3'b000, s0_h1_reg}));
        y_far  = (GW'(s0_y2_reg) + signed'({3'b000, s0_h2_reg})) - GW'(s0_y1_reg);

        vx_ext = GW'(s0_vx_reg);
        vy_ext = GW'(s0_vy_reg);
        vx_neg = s0_vx_reg[C-1];
        vy_neg = s0_vy_reg[C-1];

        if (!vx_neg && (s0_vx_reg != '0))
        begin
            xen_gap = x_near;
            xex_gap = x_far;
        end
        else
        begin
            xen_gap = x_far;
            xex_gap = x_near;
        end

        if (!vy_neg && (s0_vy_reg != '0))
        begin
            yen_gap = y_near;
            yex_gap = y_far;
        end
        else
        begin
            yen_gap = y_far;
            yex_gap = y_near;
        end

        xen_abs = xen_gap[GW-1] ? -xen_gap : xen_gap;
        xex_abs = xex_gap[GW-1] ? -xex_gap : xex_gap;
        yen_abs = yen_gap[GW-1] ? -yen_gap : yen_gap;
        yex_abs = yex_gap[GW-1] ? -yex_gap : yex_gap;
        vx_abs  = vx_neg ? -vx_ext : vx_ext;
        vy_abs  = vy_neg ? -vy_ext : vy_ext;

        s1_side_next.xinv_neg = xen_gap[GW-1];
        s1_side_next.yinv_neg = yen_gap[GW-1];
        s1_side_next.vx_zero  = (s0_vx_reg == '0);
        s1_side_next.vy_zero  = (s0_vy_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    // Quotient sign follows truncation toward zero: magnitude, then sign.
    always_ff @(posedge clk)
    begin
        s1_xen_mag_reg <= xen_abs[C:0];
        s1_xex_mag_reg <= xex_abs[C:0];
        s1_yen_mag_reg <= yen_abs[C:0];
        s1_yex_mag_reg <= yex_abs[C:0];
        s1_xen_neg_reg <= xen_gap[GW-1] ^ vx_neg;
        s1_xex_neg_reg <= xex_gap[GW-1] ^ vx_neg;
        s1_yen_neg_reg <= yen_gap[GW-1] ^ vy_neg;
        s1_yex_neg_reg <= yex_gap[GW-1] ^ vy_neg;
        s1_vx_mag_reg  <= vx_abs[C-1:0];
        s1_vy_mag_reg  <= vy_abs[C-1:0];
        s1_side_reg    <= s1_side_next;
    end

    sac_div #(.COORD_BITS(COORD_BITS), .TIME_FRAC_BITS(TIME_FRAC_BITS)) u_div_xen (
        .clk     (clk),
        .gap_mag (s1_xen_mag_reg),
        .den     (s1_vx_mag_reg),
        .neg     (s1_xen_neg_reg),
        .quot    (xen_q)
    );

    sac_div #(.COORD_BITS(COORD_BITS), .TIME_FRAC_BITS(TIME_FRAC_BITS)) u_div_xex (
        .clk     (clk),
        .gap_mag (s1_xex_mag_reg),
        .den     (s1_vx_mag_reg),
        .neg     (s1_xex_neg_reg),
        .quot    (xex_q)
    );

    sac_div #(.COORD_BITS(COORD_BITS), .TIME_FRAC_BITS(TIME_FRAC_BITS)) u_div_yen (
        .clk     (clk),
        .gap_mag (s1_yen_mag_reg),
        .den     (s1_vy_mag_reg),
        .neg     (s1_yen_neg_reg),
        .quot    (yen_q)
    );

    sac_div #(.COORD_BITS(COORD_BITS), .TIME_FRAC_BITS(TIME_FRAC_BITS)) u_div_yex (
        .clk     (clk),
        .gap_mag (s1_yex_mag_reg),
        .den     (s1_vy_mag_reg),
        .neg     (s1_yex_neg_reg),
        .quot    (yex_q)
    );

    // Valid bits and side information run in step with the dividers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_LAT; i++)
            begin
                dv_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            dv_valid_reg[0] <= s1_valid_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                dv_valid_reg[i] <= dv_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dv_side_reg[0] <= s1_side_reg;
        for (int i = 1; i < DIV_LAT; i++)
        begin
            dv_side_reg[i] <= dv_side_reg[i-1];
        end
    end

    // A still axis never limits the sweep: its window spans the full range.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
        end
        else
        begin
            m1_valid_reg <= dv_valid_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        m1_xen_reg      <= dv_side_reg[DIV_LAT-1].vx_zero ? -T_SAT : xen_q;
        m1_xex_reg      <= dv_side_reg[DIV_LAT-1].vx_zero ?  T_SAT : xex_q;
        m1_yen_reg      <= dv_side_reg[DIV_LAT-1].vy_zero ? -T_SAT : yen_q;
        m1_yex_reg      <= dv_side_reg[DIV_LAT-1].vy_zero ?  T_SAT : yex_q;
        m1_xinv_neg_reg <= dv_side_reg[DIV_LAT-1].xinv_neg;
        m1_yinv_neg_reg <= dv_side_reg[DIV_LAT-1].yinv_neg;
    end

    // Entry is the later axis entry, exit the earlier axis exit. The x face
    // is struck only when its entry is strictly later; ties go to y.
    always_comb
    begin
        x_face = (m1_xen_reg > m1_yen_reg);
        t_in   = x_face ? m1_xen_reg : m1_yen_reg;
        t_out  = (m1_xex_reg < m1_yex_reg) ? m1_xex_reg : m1_yex_reg;
        miss   = (t_in > t_out)
              || (m1_xen_reg[TW-1] && m1_yen_reg[TW-1])
              || (m1_xen_reg > T_ONE)
              || (m1_yen_reg > T_ONE);

        hit_next        = !miss;
        entry_time_next = T_ONE[TIME_FRAC_BITS:0];
        normal_x_next   = NORM_ZERO;
        normal_y_next   = NORM_ZERO;
        if (!miss)
        begin
            entry_time_next = t_in[TIME_FRAC_BITS:0];
            if (x_face)
            begin
                normal_x_next = m1_xinv_neg_reg ? NORM_POS : NORM_NEG;
            end
            else
            begin
                normal_y_next = m1_yinv_neg_reg ? NORM_POS : NORM_NEG;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg        <= hit_next;
        entry_time_reg <= entry_time_next;
        normal_x_reg   <= normal_x_next;
        normal_y_reg   <= normal_y_next;
    end

    assign done       = done_reg;
    assign hit        = hit_reg;
    assign entry_time = entry_time_reg;
    assign normal_x   = normal_x_reg;
    assign normal_y   = normal_y_reg;

    // A result only ever follows an accepted pair by the full pipeline depth.
    `SAC_ASSERT_IMPLIES(a_done_follows_start, done, $past(start && !busy, PIPE_LAT), "result without a transfer")
    // A miss reports the full step and no face.
    `SAC_ASSERT_IMPLIES(a_miss_clean, done && !hit, (entry_time == T_ONE[TIME_FRAC_BITS:0]) && (normal_x == NORM_ZERO) && (normal_y == NORM_ZERO), "miss result not clean")
    // A hit strikes exactly one face.
    `SAC_ASSERT_IMPLIES(a_hit_one_face, done && hit, (normal_x == NORM_ZERO) != (normal_y == NORM_ZERO), "hit without a single face")
    // A hit never lands beyond the end of the step.
    `SAC_ASSERT_NEVER(a_hit_in_step, done && hit && (entry_time > T_ONE[TIME_FRAC_BITS:0]), "hit time beyond one")

endmodule
